// ===== hw/rtl/bhcb_pkg.sv =====
package bhcb_pkg;

    // Default sizes of the history store.
    localparam int DEPTH_DEF       = 32;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Command codes on s_cmd.
    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_BACK    = 2'd1;
    localparam logic [1:0] CMD_FORWARD = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // an item is accepted at this edge
        logic taken;    // the result item is accepted at this edge
    } bhcb_ctl_t;

endpackage

// ===== hw/rtl/bounded_history_cursor_buffer.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------------
// input    | s_valid / s_ready  | s_cmd, s_entry_word
// result   | m_valid / m_ready  | m_entry_out, m_entry_valid, m_back_possible,
//          |                    | m_forward_possible, m_held_count
//
// One item is in flight at a time: it is accepted, its result is shown on the next
// cycle, and the next item is accepted on the cycle after the result is taken. The
// result's entry comes from the registered read of the history store.
// Reset (aresetn low, synchronous) empties the history; store contents are not cleared.
// A stalled result holds its fields and keeps s_ready low.
module bounded_history_cursor_buffer #(
    parameter int DEPTH       = bhcb_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = bhcb_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [ENTRY_WIDTH-1:0]       s_entry_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ENTRY_WIDTH-1:0]       m_entry_out,
    output logic                         m_entry_valid,
    output logic                         m_back_possible,
    output logic                         m_forward_possible,
    output logic [$clog2(DEPTH + 1)-1:0] m_held_count
);
    import bhcb_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    bhcb_ctl_t ctl;

    bhcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    bhcb_datapath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .CW          (CW)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctl                (ctl),
        .s_cmd              (s_cmd),
        .s_entry_word       (s_entry_word),
        .m_entry_out        (m_entry_out),
        .m_entry_valid      (m_entry_valid),
        .m_back_possible    (m_back_possible),
        .m_forward_possible (m_forward_possible),
        .m_held_count       (m_held_count)
    );

endmodule

// ===== hw/rtl/bhcb_ctrl.sv =====
module bhcb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output bhcb_pkg::bhcb_ctl_t ctl
);
    import bhcb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    // Handshake events handed to the datapath.
    assign ctl.load  = s_valid && s_ready_reg;
    assign ctl.taken = m_valid_reg && m_ready;

    // Next state: take one item, then hold its result until it is taken.
    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.load) begin
                    state_next   = ST_RESULT;
                    s_ready_next = 1'b0;
                    m_valid_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (ctl.taken) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                    m_valid_next = 1'b0;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_reg == ST_IDLE && !ctl.load) ? 1'b1 : s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/bhcb_datapath.sv =====
module bhcb_datapath #(
    parameter int DEPTH       = bhcb_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = bhcb_pkg::ENTRY_WIDTH_DEF,
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bhcb_pkg::bhcb_ctl_t    ctl,
    input  logic [1:0]             s_cmd,
    input  logic [ENTRY_WIDTH-1:0] s_entry_word,
    output logic [ENTRY_WIDTH-1:0] m_entry_out,
    output logic                   m_entry_valid,
    output logic                   m_back_possible,
    output logic                   m_forward_possible,
    output logic [CW-1:0]          m_held_count
);
    import bhcb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = CW + 1;

    // History store, read and written through one address.
    logic [ENTRY_WIDTH-1:0] mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] rdata_reg;
    logic                   hit_reg, hit_next;

    // Pointer state.
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cursor_reg, cursor_next;

    logic [AW-1:0] addr;
    logic          wr_en;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] cursor_ext;
    logic          can_back;
    logic          can_fwd;

    // Slot of an offset counted from the oldest entry; the sum stays below 2*DEPTH.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign cursor_ext = CW'(cursor_reg);
    assign cnt_eff    = (count_reg != '0) ? cursor_ext + CW'(1) : '0;
    assign can_back   = (count_reg != '0) && (cursor_reg != '0);
    assign can_fwd    = (count_reg != '0) && (cursor_ext + CW'(1) < count_reg);

    // Command decode and pointer update.
    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        hit_next    = 1'b0;
        wr_en       = 1'b0;
        addr        = slot_of(oldest_reg, cursor_ext);
        unique case (s_cmd)
            CMD_APPEND: begin
                // Entries after the cursor are dropped; the new one goes right after it.
                wr_en = 1'b1;
                addr  = slot_of(oldest_reg, cnt_eff);
                if (cnt_eff == CW'(DEPTH)) begin
                    oldest_next = slot_of(oldest_reg, CW'(1));
                    cursor_next = AW'(DEPTH - 1);
                end else begin
                    count_next  = cnt_eff + CW'(1);
                    cursor_next = cnt_eff[AW-1:0];
                end
            end
            CMD_BACK: begin
                if (can_back) begin
                    cursor_next = cursor_reg - AW'(1);
                    hit_next    = 1'b1;
                    addr        = slot_of(oldest_reg, CW'(cursor_reg - AW'(1)));
                end
            end
            CMD_FORWARD: begin
                if (can_fwd) begin
                    cursor_next = cursor_reg + AW'(1);
                    hit_next    = 1'b1;
                    addr        = slot_of(oldest_reg, cursor_ext + CW'(1));
                end
            end
            default: begin
                // Unused code: no change.
            end
        endcase
    end

    // Pointer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            hit_reg    <= 1'b0;
        end else if (ctl.load) begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            hit_reg    <= hit_next;
        end
    end

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (ctl.load && wr_en) begin
            mem[addr] <= s_entry_word;
        end
        if (ctl.load && !wr_en) begin
            rdata_reg <= mem[addr];
        end
    end

    // Result fields follow the state left by the last item.
    assign m_entry_out        = hit_reg ? rdata_reg : '0;
    assign m_entry_valid      = hit_reg;
    assign m_back_possible    = can_back;
    assign m_forward_possible = can_fwd;
    assign m_held_count       = count_reg;

endmodule

// ===== hw/rtl/bhcb_checker.sv =====
module bhcb_checker #(
    parameter int DEPTH       = bhcb_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = bhcb_pkg::ENTRY_WIDTH_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ENTRY_WIDTH-1:0]       m_entry_out,
    input logic                         m_entry_valid,
    input logic                         m_back_possible,
    input logic                         m_forward_possible,
    input logic [$clog2(DEPTH + 1)-1:0] m_held_count
);

    // Only one item is in flight, so input and result are never offered together.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // Every accepted item produces a result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after an accepted item");

    // A result without a cursor move carries a zero entry.
    a_zero_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_entry_valid) |-> (m_entry_out == '0))
        else $error("entry shown without a cursor move");

    // An empty history allows no navigation.
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_held_count == '0) |-> (!m_back_possible && !m_forward_possible))
        else $error("navigation possible on an empty history");

    // A stalled result keeps its fill level.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_held_count)))
        else $error("stalled result changed");

endmodule

bind bounded_history_cursor_buffer bhcb_checker #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
) u_bhcb_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_entry_out        (m_entry_out),
    .m_entry_valid      (m_entry_valid),
    .m_back_possible    (m_back_possible),
    .m_forward_possible (m_forward_possible),
    .m_held_count       (m_held_count)
);

// ===== test/tb_bounded_history_cursor_buffer.sv =====
module tb_bounded_history_cursor_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    import bhcb_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int EW         = ENTRY_WIDTH_DEF;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int NUM_RANDOM = 1650;
    localparam int STALL_MAX  = 2000;

    // Code 3 is not a defined command; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [EW-1:0] entry;
        logic          entry_ok;
        logic          can_back;
        logic          can_fwd;
        logic [CW-1:0] held;
    } nav_status_t;

    // Predicts the navigation result of every accepted command and checks
    // the results in order.
    class history_scoreboard;
        logic [EW-1:0] entry_copy [DEPTH];
        int unsigned   oldest;
        int unsigned   held;
        int unsigned   cursor;
        nav_status_t   awaited [$];
        int unsigned   errors;

        function new();
            oldest = 0;
            held   = 0;
            cursor = 0;
            errors = 0;
        endfunction

        function int unsigned slot_at(int unsigned offset);
            return (oldest + offset) % DEPTH;
        endfunction

        function void note_command(logic [1:0] cmd, logic [EW-1:0] word);
            nav_status_t r;
            r = '0;
            case (cmd)
                CMD_APPEND: begin
                    // Everything after the cursor is discarded first.
                    if (held > 0)
                        held = cursor + 1;
                    entry_copy[slot_at(held)] = word;
                    held++;
                    cursor = held - 1;
                    // Overflow drops the oldest entry.
                    if (held > DEPTH) begin
                        oldest = slot_at(1);
                        held--;
                        cursor--;
                    end
                end
                CMD_BACK: begin
                    if (held > 0 && cursor > 0) begin
                        cursor--;
                        r.entry    = entry_copy[slot_at(cursor)];
                        r.entry_ok = 1'b1;
                    end
                end
                CMD_FORWARD: begin
                    if (held > 0 && cursor + 1 < held) begin
                        cursor++;
                        r.entry    = entry_copy[slot_at(cursor)];
                        r.entry_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.can_back = (held > 0 && cursor > 0);
            r.can_fwd  = (held > 0 && cursor + 1 < held);
            r.held     = CW'(held);
            awaited = {awaited, r};
        endfunction

        function void check_result(nav_status_t got);
            nav_status_t exp;
            if (awaited.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
                return;
            end
            exp = awaited[0];
            awaited.delete(0);
            if (got.entry !== exp.entry) begin
                $error("entry_out: expected %h, got %h", exp.entry, got.entry);
                errors++;
            end
            if (got.entry_ok !== exp.entry_ok) begin
                $error("entry_valid: expected %b, got %b", exp.entry_ok, got.entry_ok);
                errors++;
            end
            if (got.can_back !== exp.can_back) begin
                $error("back_possible: expected %b, got %b", exp.can_back, got.can_back);
                errors++;
            end
            if (got.can_fwd !== exp.can_fwd) begin
                $error("forward_possible: expected %b, got %b", exp.can_fwd, got.can_fwd);
                errors++;
            end
            if (got.held !== exp.held) begin
                $error("held_count: expected %0d, got %0d", exp.held, got.held);
                errors++;
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [1:0]    s_cmd;
    logic [EW-1:0] s_entry_word;
    logic          m_valid;
    logic          m_ready;
    logic [EW-1:0] m_entry_out;
    logic          m_entry_valid;
    logic          m_back_possible;
    logic          m_forward_possible;
    logic [CW-1:0] m_held_count;

    history_scoreboard sb;
    bit                no_idle;
    int unsigned       quiet_cycles;

    bounded_history_cursor_buffer dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_entry_word       (s_entry_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_entry_out        (m_entry_out),
        .m_entry_valid      (m_entry_valid),
        .m_back_possible    (m_back_possible),
        .m_forward_possible (m_forward_possible),
        .m_held_count       (m_held_count)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // The result side stalls at random, with a chance of about 9 in 100, unless idling is off.
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 9);
    end

    // Both channels are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command(s_cmd, s_entry_word);
            if (m_valid && m_ready)
                sb.check_result({m_entry_out, m_entry_valid, m_back_possible,
                                 m_forward_possible, m_held_count});
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(logic [1:0] cmd, logic [EW-1:0] word);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_entry_word <= word;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge aclk);
    endtask

    // Picks a command according to the current traffic mix.
    function automatic logic [1:0] pick_command(int unsigned mix);
        int unsigned p;
        p = $urandom_range(99);
        case (mix)
            0: return (p < 75) ? CMD_APPEND : (p < 88) ? CMD_BACK :
                      (p < 98) ? CMD_FORWARD : CMD_UNUSED;
            1: return (p < 8) ? CMD_APPEND : (p < 53) ? CMD_BACK :
                      (p < 98) ? CMD_FORWARD : CMD_UNUSED;
            2: return (p < 40) ? CMD_APPEND : (p < 68) ? CMD_BACK :
                      (p < 96) ? CMD_FORWARD : CMD_UNUSED;
            default: return CMD_APPEND;
        endcase
    endfunction

    initial begin
        int unsigned mix;
        sb           = new();
        no_idle      = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_APPEND;
        s_entry_word = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty store: navigation fails and the unused code does nothing.
        send_command(CMD_BACK, '0);
        send_command(CMD_FORWARD, '1);
        send_command(CMD_UNUSED, '0);
        // A single entry: no move in either direction.
        send_command(CMD_APPEND, '0);
        send_command(CMD_BACK, '0);
        send_command(CMD_FORWARD, '0);
        // Extreme words, then walk down to the oldest and past it.
        send_command(CMD_APPEND, '1);
        send_command(CMD_APPEND, 32'hA5A5_A5A5);
        send_command(CMD_BACK, '0);
        send_command(CMD_BACK, '0);
        send_command(CMD_BACK, '0);
        send_command(CMD_FORWARD, '0);
        // Append in the middle truncates the newer entries.
        send_command(CMD_APPEND, 32'h5A5A_5A5A);
        send_command(CMD_FORWARD, '0);
        send_command(CMD_UNUSED, '1);
        send_command(CMD_BACK, '0);
        send_command(CMD_FORWARD, '0);
        drain_results();
        @(negedge aclk);

        // Random traffic in phases of different mixes; long append bursts
        // fill the store and make it wrap.
        mix = 3;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 60 == 0)
                mix = $urandom_range(3);
            no_idle = (i >= 500 && i < 800);
            if (i == 900) begin
                drain_results();
                @(negedge aclk);
            end
            send_command(pick_command(mix), $urandom());
        end
        no_idle = 1'b0;
        drain_results();
        repeat (10) @(posedge aclk);

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
